// ----- sv/sswd_pkg.sv -----
// Package for the sampled SPI word decoder.
// Holds configuration, sample and result types plus register index codes.
// No dependencies.
package sswd_pkg;

    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SELECT_ACTIVE_LEVEL = 3'd0,
        CFG_CLOCK_IDLE_LEVEL    = 3'd1,
        CFG_CLOCK_PHASE         = 3'd2,
        CFG_LSB_FIRST           = 3'd3,
        CFG_WORD_BITS           = 3'd4
    } t_cfg_idx;

    localparam logic [3:0] WORD_BITS_RESET = 4'd8;
    localparam logic [2:0] BIT_POS_LAST    = 3'd7;

    typedef struct packed {
        logic       select_active_level;
        logic       clock_idle_level;
        logic       clock_phase;
        logic       lsb_first;
        logic [3:0] word_bits;
    } t_cfg;

    typedef struct packed {
        logic select_line;
        logic clock_line;
        logic data_a_line;
        logic data_b_line;
    } t_sample;

    typedef struct packed {
        logic [7:0] word_a;
        logic [7:0] word_b;
        logic       word_complete;
    } t_result;

endpackage

// ----- sv/spi_sampled_word_decoder.sv -----
// Top level of the sampled SPI word decoder: config registers, sample
// input register, result register. Depends on sswd_pkg and sswd_core.
//
//   channel   signals                                 direction
//   sample    i_in_valid / o_in_ready, 4 line levels  in
//   word      o_out_valid / i_out_ready, a, b, flag   out
//   config    i_cfg_we, i_cfg_index, i_cfg_data       in
//
// One sample per clock unless stalled; an accepted sample sits in the input
// register; its word, if any, shows on the outputs when the sample advances.
// Reset clears config to defaults and empties both registers.
// A stalled word blocks only samples that would produce another word.
module spi_sampled_word_decoder
    import sswd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_select_line,
    input  logic                  i_clock_line,
    input  logic                  i_data_a_line,
    input  logic                  i_data_b_line,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_word_a,
    output logic [7:0]            o_word_b,
    output logic                  o_word_complete
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_out_valid;
    t_result r_out;

    logic    w_advance;
    logic    w_res_valid;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{select_active_level: 1'b0, clock_idle_level: 1'b0,
                       clock_phase: 1'b0, lsb_first: 1'b0,
                       word_bits: WORD_BITS_RESET};
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SELECT_ACTIVE_LEVEL: r_cfg.select_active_level <= i_cfg_data[0];
                CFG_CLOCK_IDLE_LEVEL:    r_cfg.clock_idle_level    <= i_cfg_data[0];
                CFG_CLOCK_PHASE:         r_cfg.clock_phase         <= i_cfg_data[0];
                CFG_LSB_FIRST:           r_cfg.lsb_first           <= i_cfg_data[0];
                CFG_WORD_BITS:           r_cfg.word_bits           <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance unless the sample yields a word and the result slot stays full
    assign w_advance  = r_in_valid && (!w_res_valid || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_sample <= '{select_line: i_select_line, clock_line: i_clock_line,
                             data_a_line: i_data_a_line, data_b_line: i_data_b_line};
        end
    end

    sswd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_sample   (r_in_sample),
        .i_advance  (w_advance),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_word_a        = r_out.word_a;
    assign o_word_b        = r_out.word_b;
    assign o_word_complete = r_out.word_complete;

endmodule

// ----- sv/sswd_core.sv -----
// Decoder core: word state registers and the per-sample next-state logic.
// Depends on sswd_pkg.
module sswd_core
    import sswd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_sample i_sample,
    input  logic    i_advance,
    output logic    o_res_valid,
    output t_result o_res
);

    logic       r_word_active;
    logic       r_prev_clock;
    logic [4:0] r_edge_count;
    logic [2:0] r_bit_pos;
    logic [7:0] r_shift_a;
    logic [7:0] r_shift_b;

    logic       n_word_active;
    logic [4:0] n_edge_count;
    logic [2:0] n_bit_pos;
    logic [7:0] n_shift_a;
    logic [7:0] n_shift_b;

    logic       w_start;
    logic       w_edge;
    logic       w_leading;
    logic       w_capture;
    logic [2:0] w_pos;
    logic [7:0] w_cap_a;
    logic [7:0] w_cap_b;
    logic [4:0] w_cnt_inc;
    logic [4:0] w_cnt_limit;

    always_comb begin
        w_start     = !r_word_active && (r_prev_clock == i_cfg.clock_idle_level)
                      && (i_sample.clock_line != i_cfg.clock_idle_level);
        w_edge      = w_start || (r_word_active && (i_sample.clock_line != r_prev_clock));
        w_leading   = i_sample.clock_line != i_cfg.clock_idle_level;
        w_capture   = i_cfg.clock_phase ? !w_leading : w_leading;
        w_pos       = i_cfg.lsb_first ? r_bit_pos : (BIT_POS_LAST - r_bit_pos);
        w_cap_a     = r_shift_a | (8'(i_sample.data_a_line) << w_pos);
        w_cap_b     = r_shift_b | (8'(i_sample.data_b_line) << w_pos);
        w_cnt_inc   = r_edge_count + 5'd1;
        w_cnt_limit = {i_cfg.word_bits, 1'b0};

        n_word_active = r_word_active;
        n_edge_count  = r_edge_count;
        n_bit_pos     = r_bit_pos;
        n_shift_a     = r_shift_a;
        n_shift_b     = r_shift_b;
        o_res_valid   = 1'b0;
        o_res         = '{word_a: r_shift_a, word_b: r_shift_b, word_complete: 1'b0};

        if (i_sample.select_line == i_cfg.select_active_level) begin
            if (w_edge) begin
                n_word_active = 1'b1;
                if (w_capture) begin
                    n_shift_a = w_cap_a;
                    n_shift_b = w_cap_b;
                    if (r_bit_pos != BIT_POS_LAST) begin
                        n_bit_pos = r_bit_pos + 3'd1;
                    end
                end
                n_edge_count = w_cnt_inc;
                if (w_cnt_inc >= w_cnt_limit) begin
                    o_res_valid   = 1'b1;
                    o_res         = '{word_a: n_shift_a, word_b: n_shift_b,
                                      word_complete: 1'b1};
                    n_word_active = 1'b0;
                    n_edge_count  = '0;
                    n_bit_pos     = '0;
                    n_shift_a     = '0;
                    n_shift_b     = '0;
                end
            end
        end else begin
            o_res_valid   = r_word_active;
            n_word_active = 1'b0;
            n_edge_count  = '0;
            n_bit_pos     = '0;
            n_shift_a     = '0;
            n_shift_b     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_active <= 1'b0;
            r_prev_clock  <= 1'b0;
            r_edge_count  <= '0;
            r_bit_pos     <= '0;
            r_shift_a     <= '0;
            r_shift_b     <= '0;
        end else if (i_advance) begin
            r_word_active <= n_word_active;
            r_prev_clock  <= i_sample.clock_line;
            r_edge_count  <= n_edge_count;
            r_bit_pos     <= n_bit_pos;
            r_shift_a     <= n_shift_a;
            r_shift_b     <= n_shift_b;
        end
    end

endmodule
